### hw/rtl/vdld_pkg.sv
// Package for the vector display list decoder.
// Holds the opcode codes, the queued command type and shared sizes.
// No dependencies.
package vdld_pkg;

    localparam int WORD_W      = 16;
    localparam int BRIGHT_W    = 5;
    localparam int SCALE_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] OP_LONG_MAX = 4'h9;
    localparam logic [3:0] OP_LABS     = 4'hA;
    localparam logic [3:0] OP_RTSL     = 4'hD;
    localparam logic [3:0] OP_SVEC     = 4'hF;

    localparam logic [WORD_W-1:0] DAC_MASK = 16'hFFFC;

    typedef enum logic [1:0] {
        CMD_SEG  = 2'd0,
        CMD_LABS = 2'd1,
        CMD_END  = 2'd2
    } cmd_kind_t;

    // One decoded instruction travelling from front to back.
    // For CMD_SEG, dx/dy are pre-scaled deltas before global scale and mirror.
    // For CMD_LABS, dx/dy are the new beam position.
    typedef struct packed {
        cmd_kind_t             kind;
        logic [WORD_W-1:0]     dx;
        logic [WORD_W-1:0]     dy;
        logic [BRIGHT_W-1:0]   bright;
        logic [SCALE_W-1:0]    scale;
        logic                  mirror_x;
        logic                  mirror_y;
        logic                  bad;
    } cmd_t;

endpackage

### hw/rtl/vdld_front.sv
// Front end of the vector display list decoder: accepts list words,
// pairs two-word opcodes and classifies them into queued commands.
// Depends on vdld_pkg.
module vdld_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [vdld_pkg::WORD_W-1:0]         s_tdata,
    input  logic [2:0]                          s_tuser,
    input  logic                                q_full,
    output logic                                q_push,
    output vdld_pkg::cmd_t                      q_cmd
);

    logic                        awaiting_reg, awaiting_next;
    logic [vdld_pkg::WORD_W-1:0] held_reg, held_next;

    logic                        accept;
    logic                        hold_first;
    logic [vdld_pkg::WORD_W-1:0] w;
    logic [3:0]                  op;
    logic [3:0]                  first_op;

    function automatic logic [vdld_pkg::WORD_W-1:0] sign_mag(
        input logic [vdld_pkg::WORD_W-1:0] mag,
        input logic                        neg
    );
        return neg ? (16'd0 - mag) : mag;
    endfunction

    // times four, then arithmetic shift right
    function automatic logic [vdld_pkg::WORD_W-1:0] prescale(
        input logic [vdld_pkg::WORD_W-1:0] d,
        input logic [3:0]                  rsh
    );
        logic signed [vdld_pkg::WORD_W-1:0] t;
        t = $signed({d[13:0], 2'b00});
        return t >>> rsh;
    endfunction

    assign w        = s_tdata;
    assign op       = w[15:12];
    assign first_op = held_reg[15:12];
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        q_cmd          = '0;
        q_cmd.kind     = vdld_pkg::CMD_END;
        q_cmd.mirror_x = s_tuser[0];
        q_cmd.mirror_y = s_tuser[1];
        hold_first     = 1'b0;
        if (awaiting_reg) begin
            if (first_op == vdld_pkg::OP_LABS) begin
                q_cmd.kind  = vdld_pkg::CMD_LABS;
                q_cmd.dy    = {4'd0, held_reg[9:0], 2'b00};
                q_cmd.dx    = {4'd0, w[9:0], 2'b00};
                q_cmd.scale = w[15:12];
            end else begin
                q_cmd.kind   = vdld_pkg::CMD_SEG;
                q_cmd.dy     = prescale(sign_mag({6'd0, held_reg[9:0]}, held_reg[10]),
                                        vdld_pkg::OP_LONG_MAX - first_op);
                q_cmd.dx     = prescale(sign_mag({6'd0, w[9:0]}, w[10]),
                                        vdld_pkg::OP_LONG_MAX - first_op);
                q_cmd.bright = {1'b0, w[15:12]};
            end
        end else begin
            unique case (op) inside
                [4'h0:vdld_pkg::OP_LONG_MAX], vdld_pkg::OP_LABS: begin
                    hold_first = 1'b1;
                end
                vdld_pkg::OP_SVEC: begin
                    q_cmd.kind   = vdld_pkg::CMD_SEG;
                    q_cmd.dy     = prescale(sign_mag({6'd0, w[9:8], 8'd0}, w[10]),
                                            4'd7 - {2'b00, w[3], w[11]});
                    q_cmd.dx     = prescale(sign_mag({6'd0, w[1:0], 8'd0}, w[2]),
                                            4'd7 - {2'b00, w[3], w[11]});
                    q_cmd.bright = {1'b0, w[7:4]} + (s_tuser[2] ? 5'd2 : 5'd0);
                end
                default: begin
                    q_cmd.kind = vdld_pkg::CMD_END;
                    q_cmd.bad  = (op != vdld_pkg::OP_RTSL);
                end
            endcase
        end
    end

    assign q_push = accept && !hold_first;

    always_comb begin
        awaiting_next = awaiting_reg;
        held_next     = held_reg;
        if (accept) begin
            awaiting_next = hold_first;
            if (hold_first) begin
                held_next = w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg <= 1'b0;
            held_reg     <= '0;
        end else begin
            awaiting_reg <= awaiting_next;
            held_reg     <= held_next;
        end
    end

endmodule

### hw/rtl/vdld_queue.sv
// Short command queue between decoder front and back.
// Depends on vdld_pkg.
module vdld_queue #(
    parameter int DEPTH = vdld_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  vdld_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output vdld_pkg::cmd_t head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    vdld_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/vdld_back.sv
// Back end of the vector display list decoder: keeps beam position, global
// scale and DAC mode, executes queued commands into the output register.
// Depends on vdld_pkg.
module vdld_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         q_not_empty,
    input  vdld_pkg::cmd_t               q_head,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [71:0]                  m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);

    logic [vdld_pkg::WORD_W-1:0]  beam_x_reg, beam_x_next;
    logic [vdld_pkg::WORD_W-1:0]  beam_y_reg, beam_y_next;
    logic [vdld_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic                         dac_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [vdld_pkg::WORD_W-1:0]  start_x_reg, start_x_next;
    logic [vdld_pkg::WORD_W-1:0]  start_y_reg, start_y_next;
    logic [vdld_pkg::WORD_W-1:0]  step_x_reg, step_x_next;
    logic [vdld_pkg::WORD_W-1:0]  step_y_reg, step_y_next;
    logic [vdld_pkg::BRIGHT_W-1:0] bright_reg, bright_next;
    logic                         visible_reg, visible_next;
    logic                         finished_reg, finished_next;
    logic                         bad_reg, bad_next;

    logic                         slot_free;
    logic [vdld_pkg::WORD_W-1:0]  seg_dx, seg_dy;
    logic [vdld_pkg::WORD_W-1:0]  pos_mask;

    function automatic logic [vdld_pkg::WORD_W-1:0] apply_scale(
        input logic [vdld_pkg::WORD_W-1:0]  t,
        input logic [vdld_pkg::SCALE_W-1:0] sc
    );
        logic signed [vdld_pkg::WORD_W-1:0] ts;
        ts = $signed(t);
        // codes 8..15 shift right by 16 - code
        if (sc[3]) begin
            return ts >>> (4'd0 - sc);
        end
        return t << sc[2:0];
    endfunction

    assign slot_free = !out_valid_reg || m_tready;
    assign q_pop     = q_not_empty && slot_free;
    assign pos_mask  = dac_reg ? vdld_pkg::DAC_MASK : 16'hFFFF;

    always_comb begin
        seg_dx = apply_scale(q_head.dx, scale_reg);
        seg_dy = apply_scale(q_head.dy, scale_reg);
        if (q_head.mirror_x) begin
            seg_dx = 16'd0 - seg_dx;
        end
        if (q_head.mirror_y) begin
            seg_dy = 16'd0 - seg_dy;
        end
    end

    always_comb begin
        beam_x_next    = beam_x_reg;
        beam_y_next    = beam_y_reg;
        scale_next     = scale_reg;
        out_valid_next = out_valid_reg && !m_tready;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        bright_next    = bright_reg;
        visible_next   = visible_reg;
        finished_next  = finished_reg;
        bad_next       = bad_reg;
        if (q_pop) begin
            case (q_head.kind)
                vdld_pkg::CMD_SEG: begin
                    out_valid_next = 1'b1;
                    start_x_next   = beam_x_reg & pos_mask;
                    start_y_next   = beam_y_reg & pos_mask;
                    step_x_next    = seg_dx;
                    step_y_next    = seg_dy;
                    bright_next    = q_head.bright;
                    visible_next   = (q_head.bright != '0);
                    finished_next  = 1'b0;
                    bad_next       = 1'b0;
                    beam_x_next    = beam_x_reg + seg_dx;
                    beam_y_next    = beam_y_reg + seg_dy;
                end
                vdld_pkg::CMD_LABS: begin
                    beam_x_next = q_head.dx;
                    beam_y_next = q_head.dy;
                    scale_next  = q_head.scale;
                end
                default: begin
                    out_valid_next = 1'b1;
                    start_x_next   = '0;
                    start_y_next   = '0;
                    step_x_next    = '0;
                    step_y_next    = '0;
                    bright_next    = '0;
                    visible_next   = 1'b0;
                    finished_next  = 1'b1;
                    bad_next       = q_head.bad;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beam_x_reg    <= '0;
            beam_y_reg    <= '0;
            scale_reg     <= '0;
            dac_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            beam_x_reg    <= beam_x_next;
            beam_y_reg    <= beam_y_next;
            scale_reg     <= scale_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                dac_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        start_x_reg  <= start_x_next;
        start_y_reg  <= start_y_next;
        step_x_reg   <= step_x_next;
        step_y_reg   <= step_y_next;
        bright_reg   <= bright_next;
        visible_reg  <= visible_next;
        finished_reg <= finished_next;
        bad_reg      <= bad_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, visible_reg, bright_reg, step_y_reg, step_x_reg,
                       start_y_reg, start_x_reg};
    assign m_tlast  = finished_reg;
    assign m_tuser  = bad_reg;

endmodule

### hw/rtl/vector_display_list_decoder.sv
// Vector display list decoder, top level.
// Throughput: one list word per cycle while m_tready stays high, with a
// combinational decode in the front and a combinational scale/add in the back.
// A segment or end result is written into the queue when its last word is
// transferred and moves on to the output register once that register is free.
// LABS gives no result. Reset (aresetn low, synchronous) clears beam, scale,
// pending word, queue, output valid and DAC mode.
module vector_display_list_decoder #(
    parameter int QUEUE_DEPTH = vdld_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,       // dac_ten_bit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,         // instr_word
    input  logic [2:0]  s_tuser,         // mirror_x, mirror_y, boost
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,         // start_x, start_y, step_x, step_y,
                                         // intensity[4:0], visible, 2'b0 pad
    output logic        m_tlast,         // finished
    output logic        m_tuser          // bad_opcode
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    vdld_pkg::cmd_t q_in;
    vdld_pkg::cmd_t q_head;

    vdld_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    vdld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (q_head)
    );

    vdld_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

### test/tb_vector_display_list_decoder.sv
// Self-checking testbench for vector_display_list_decoder.
// Streams vector-list words through a randomised driver and checks every result transfer
// against an in-bench decoder model; depends on vdld_pkg and the RTL only.
module tb_vector_display_list_decoder;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int WORDS_PER_PHASE = 100;

    // Opcodes the decoder rejects
    localparam logic [3:0] OP_SPARE_B = 4'hB;
    localparam logic [3:0] OP_SPARE_C = 4'hC;
    localparam logic [3:0] OP_SPARE_E = 4'hE;

    typedef struct {
        logic [15:0] word;
        logic [2:0]  flags;   // mirror_x, mirror_y, boost
        bit          drain;   // hold back until every result is in
    } list_item_t;

    typedef struct packed {
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] step_x;
        logic [15:0] step_y;
        logic [4:0]  intensity;
        logic        visible;
        logic        finished;
        logic        bad_opcode;
    } beam_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    list_item_t   pending_words[$];
    beam_result_t results_due[$];
    list_item_t   next_word;

    // Decoder model state
    logic [15:0] beam_x, beam_y, held_word;
    logic [3:0]  scale_code;
    logic        awaiting_second;
    logic        dac_mode;

    int  cycle_count = 0;
    int  error_count = 0;
    int  words_queued = 0;
    int  words_sent = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  s_taken = 1'b0;
    bit  calm = 1'b0;

    vector_display_list_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] arith_shr(logic [15:0] v, int sh);
        logic signed [15:0] sv;
        sv = v;
        return sv >>> sh;
    endfunction

    function automatic logic [15:0] apply_sign(logic [15:0] mag, logic neg);
        return neg ? (16'd0 - mag) : mag;
    endfunction

    // Local shift, then global scale: left for 0..7, arithmetic right by 16-scale for 8..15
    function automatic logic [15:0] scale_step(logic [15:0] d, int rsh);
        logic [15:0] t;
        t = {d[13:0], 2'b00};
        t = arith_shr(t, rsh);
        if (scale_code <= 4'd7)
            t = t << scale_code;
        else
            t = arith_shr(t, 16 - int'(scale_code));
        return t;
    endfunction

    function automatic void emit_segment(logic [15:0] dx, logic [15:0] dy,
                                         logic [4:0] bright, logic mx, logic my);
        beam_result_t r;
        logic [15:0] mask;
        mask = dac_mode ? vdld_pkg::DAC_MASK : 16'hFFFF;
        if (mx)
            dx = 16'd0 - dx;
        if (my)
            dy = 16'd0 - dy;
        r.start_x    = beam_x & mask;
        r.start_y    = beam_y & mask;
        r.step_x     = dx;
        r.step_y     = dy;
        r.intensity  = bright;
        r.visible    = (bright != 5'd0);
        r.finished   = 1'b0;
        r.bad_opcode = 1'b0;
        results_due.push_back(r);
        beam_x = beam_x + dx;
        beam_y = beam_y + dy;
    endfunction

    function automatic void decode_list_word(logic [15:0] w, logic [2:0] flags);
        beam_result_t r;
        logic [3:0]  op;
        logic [15:0] dx, dy;
        logic [4:0]  bright;
        int          rsh;
        if (awaiting_second) begin
            awaiting_second = 1'b0;
            op = held_word[15:12];
            if (op == vdld_pkg::OP_LABS) begin
                beam_y = {4'b0, held_word[9:0], 2'b00};
                beam_x = {4'b0, w[9:0], 2'b00};
                scale_code = w[15:12];
            end else begin
                dy = apply_sign({6'b0, held_word[9:0]}, held_word[10]);
                dx = apply_sign({6'b0, w[9:0]}, w[10]);
                rsh = 9 - int'(op);
                emit_segment(scale_step(dx, rsh), scale_step(dy, rsh), {1'b0, w[15:12]},
                             flags[0], flags[1]);
            end
            return;
        end
        op = w[15:12];
        if (op <= vdld_pkg::OP_LONG_MAX || op == vdld_pkg::OP_LABS) begin
            held_word = w;
            awaiting_second = 1'b1;
        end else if (op == vdld_pkg::OP_SVEC) begin
            dy = apply_sign({6'b0, w[9:8], 8'b0}, w[10]);
            dx = apply_sign({6'b0, w[1:0], 8'b0}, w[2]);
            rsh = 7 - int'({w[3], w[11]});
            bright = {1'b0, w[7:4]} + (flags[2] ? 5'd2 : 5'd0);
            emit_segment(scale_step(dx, rsh), scale_step(dy, rsh), bright, flags[0], flags[1]);
        end else begin
            r = '0;
            r.finished = 1'b1;
            r.bad_opcode = (op != vdld_pkg::OP_RTSL);
            results_due.push_back(r);
        end
    endfunction

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task automatic check_result();
        beam_result_t want;
        if (results_due.size() == 0) begin
            report_error($sformatf("unexpected result tdata %h last %b user %b",
                                   m_tdata, m_tlast, m_tuser));
            return;
        end
        want = results_due.pop_front();
        check_field("start_x", m_tdata[15:0], want.start_x);
        check_field("start_y", m_tdata[31:16], want.start_y);
        check_field("step_x", m_tdata[47:32], want.step_x);
        check_field("step_y", m_tdata[63:48], want.step_y);
        check_field("intensity", {11'b0, m_tdata[68:64]}, {11'b0, want.intensity});
        check_field("visible", {15'b0, m_tdata[69]}, {15'b0, want.visible});
        check_field("finished", {15'b0, m_tlast}, {15'b0, want.finished});
        check_field("bad_opcode", {15'b0, m_tuser}, {15'b0, want.bad_opcode});
    endtask

    // Monitor: sample both channels at the rising edge and run the model
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end else if (!aresetn) begin
            beam_x = '0;
            beam_y = '0;
            held_word = '0;
            scale_code = '0;
            awaiting_second = 1'b0;
            dac_mode = 1'b0;
            s_taken = 1'b0;
        end else begin
            if (cfg_we)
                dac_mode = cfg_wdata;
            if (m_tvalid && m_tready)
                check_result();
            s_taken = s_tvalid && s_tready;
            if (s_taken) begin
                decode_list_word(s_tdata, s_tuser);
                words_sent++;
            end
        end
    end

    // Word driver: advance on the falling edge once the previous transfer is done
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain && results_due.size() != 0)) begin
                next_word = pending_words.pop_front();
                s_tdata  <= next_word.word;
                s_tuser  <= next_word.flags;
                s_tvalid <= 1'b1;
                gap_left = calm ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink with random back-pressure
    always @(negedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_tready <= (stall_left == 0);
        end
    end

    task automatic push_word(input logic [15:0] w, input logic [2:0] flags, input bit drain);
        list_item_t it;
        it.word = w;
        it.flags = flags;
        it.drain = drain;
        pending_words.push_back(it);
        words_queued++;
    endtask

    task automatic wait_idle();
        while (words_sent != words_queued || results_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic queue_directed();
        push_word({vdld_pkg::OP_LABS, 12'h3FF}, 3'd0, 1'b0);   // corner position, scale 15
        push_word({vdld_pkg::OP_SVEC, 12'h3FF}, 3'd0, 1'b0);   // second word with SVEC top bits
        push_word({4'h9, 12'h7FF}, 3'd0, 1'b0);
        push_word({4'h0, 12'h7FF}, 3'd3, 1'b0);        // zero brightness: invisible move
        push_word({vdld_pkg::OP_LABS, 12'h000}, 3'd0, 1'b0);
        push_word({4'h7, 12'h000}, 3'd0, 1'b0);        // scale 7
        push_word({4'h9, 12'h3FF}, 3'd0, 1'b0);        // largest long vector, wraps
        push_word({4'hF, 12'h3FF}, 3'd0, 1'b0);
        push_word({4'h0, 12'h401}, 3'd1, 1'b0);
        push_word({4'h8, 12'h401}, 3'd2, 1'b0);
        push_word({4'h5, 12'h400}, 3'd0, 1'b0);
        push_word({4'h4, 12'h155}, 3'd5, 1'b0);
        push_word({vdld_pkg::OP_SVEC, 12'hFFF}, 3'd7, 1'b0);   // boosted to brightness 17
        push_word({vdld_pkg::OP_SVEC, 12'h000}, 3'd0, 1'b0);
        push_word({vdld_pkg::OP_LABS, 12'h155}, 3'd0, 1'b0);
        push_word({4'h8, 12'h2AA}, 3'd0, 1'b0);        // scale 8: right shifts
        push_word({vdld_pkg::OP_SVEC, 12'h8F8}, 3'd4, 1'b0);
        push_word({vdld_pkg::OP_RTSL, 12'h000}, 3'd7, 1'b0);
        push_word({vdld_pkg::OP_RTSL, 12'hFFF}, 3'd0, 1'b0);
        push_word({OP_SPARE_B, 12'h123}, 3'd0, 1'b0);
        push_word({OP_SPARE_C, 12'hFFF}, 3'd7, 1'b0);
        push_word({OP_SPARE_E, 12'h000}, 3'd0, 1'b0);
        push_word({vdld_pkg::OP_SVEC, 12'h777}, 3'd3, 1'b0);
    endtask

    // Mostly well-formed commands with random content, a few rejected opcodes
    task automatic queue_random(input int count);
        int          sent, pick, drain_at;
        logic [15:0] w1, w2;
        logic [3:0]  op;
        bit          drain;
        sent = 0;
        drain_at = $urandom_range(10, count - 10);
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            w1 = 16'($urandom);
            w2 = 16'($urandom);
            drain = (sent <= drain_at && drain_at < sent + 2);
            if (pick < 45) begin
                op = 4'($urandom_range(0, 9));
                push_word({op, w1[11:0]}, 3'($urandom_range(0, 7)), drain);
                push_word(w2, 3'($urandom_range(0, 7)), 1'b0);
                sent += 2;
            end else if (pick < 60) begin
                push_word({vdld_pkg::OP_LABS, w1[11:0]}, 3'($urandom_range(0, 7)), drain);
                push_word(w2, 3'($urandom_range(0, 7)), 1'b0);
                sent += 2;
            end else begin
                if (pick < 85)
                    op = vdld_pkg::OP_SVEC;
                else if (pick < 93)
                    op = vdld_pkg::OP_RTSL;
                else if (pick < 95)
                    op = OP_SPARE_B;
                else if (pick < 97)
                    op = OP_SPARE_C;
                else
                    op = OP_SPARE_E;
                push_word({op, w1[11:0]}, 3'($urandom_range(0, 7)), drain);
                sent += 1;
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            cfg_we <= 1'b1;
            cfg_wdata <= (phase % 2 == 0);
            @(negedge aclk);
            cfg_we <= 1'b0;
            calm = (phase == 2);
            if (phase == 0)
                queue_directed();
            queue_random(WORDS_PER_PHASE);
        end
        wait_idle();
        if (error_count == 0 && results_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
